// ----- rtl/core/bps_pkg.sv -----
// bps_pkg: shared types, constants and the case-fold helper for byte_pattern_search.
// Used by bps_cell, bps_ctrl and the byte_pattern_search top level.
`default_nettype none

package bps_pkg;

  localparam int PATTERN_MAX = 16;
  localparam int OFFSET_BITS = 29;

  // The pattern registers hold sixteen bytes; deeper cells could never be compared.
  localparam int PAT_BYTES  = 16;
  localparam int PAT_LIMIT  = (PATTERN_MAX < PAT_BYTES) ? PATTERN_MAX : PAT_BYTES;
  localparam int CELL_COUNT = PAT_LIMIT;

  localparam int LEN_BITS   = 5;
  localparam int START_BITS = 30;
  localparam int COUNT_BITS = OFFSET_BITS + 1;
  localparam int CMP_BITS   = (COUNT_BITS > START_BITS) ? COUNT_BITS : START_BITS;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 64;

  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
  localparam logic [7:0] CASE_GAP     = 8'd32;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_PATTERN_LOW  = 3'd0,
    REG_PATTERN_HIGH = 3'd1,
    REG_PATTERN_LEN  = 3'd2,
    REG_START_OFFSET = 3'd3,
    REG_SEARCH_FWD   = 3'd4,
    REG_FOLD_CASE    = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic                   found;
    logic [OFFSET_BITS-1:0] match_offset;
  } result_t;

  // Settings the controller needs to qualify a window hit.
  typedef struct packed {
    logic                  len_ok;
    logic [LEN_BITS-1:0]   length;
    logic [START_BITS-1:0] start_offset;
    logic                  forward;
  } search_cfg_t;

  function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic en);
    logic [7:0] r;
    r = c;
    if (en && (c inside {[CHAR_UPPER_A:CHAR_UPPER_Z]})) r = c + CASE_GAP;
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/bps_cell.sv -----
// bps_cell: one window position; holds a byte, passes it on, compares the byte
// entering it against its pattern byte. Depends on bps_pkg.
`default_nettype none

module bps_cell
  import bps_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       shift,
  input  wire logic [7:0] byte_in,
  input  wire logic [7:0] pat_byte,
  input  wire logic       fold_case,
  input  wire logic       active,
  output logic      [7:0] byte_out,
  output logic            hit
);

  always_ff @(posedge clk) begin
    if (shift) byte_out <= byte_in;
  end

  // Inactive cells lie beyond the pattern and always agree.
  assign hit = !active || (fold_byte(byte_in, fold_case) == fold_byte(pat_byte, fold_case));

endmodule

`default_nettype wire

// ----- rtl/core/bps_ctrl.sv -----
// bps_ctrl: byte counter, match bookkeeping and the two-deep result buffer.
// Depends on bps_pkg.
`default_nettype none

module bps_ctrl
  import bps_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        accept,
  input  wire logic        last_byte,
  input  wire logic        window_hit,
  input  wire search_cfg_t scfg,
  output logic             item_stall,
  output logic             result_valid,
  input  wire logic        result_stall,
  output result_t          result
);

  logic [COUNT_BITS-1:0]  byte_count;
  logic [COUNT_BITS-1:0]  byte_count_next;
  logic                   match_seen;
  logic                   match_seen_next;
  logic [OFFSET_BITS-1:0] best_offset;
  logic [OFFSET_BITS-1:0] best_offset_next;

  logic [COUNT_BITS-1:0]  count_inc;
  logic [COUNT_BITS-1:0]  len_ext;
  logic [COUNT_BITS-1:0]  start_pos;
  logic                   counting;
  logic                   qualify;
  result_t                res_new;
  result_t                skid;
  logic                   skid_valid;
  logic                   push;

  assign count_inc = byte_count + COUNT_BITS'(1);
  assign len_ext   = COUNT_BITS'(scfg.length);
  assign start_pos = count_inc - len_ext;
  // Counter stops at 2^OFFSET_BITS; the top bit alone marks saturation.
  assign counting  = !byte_count[COUNT_BITS-1];

  always_comb begin
    qualify = 1'b0;
    if (counting && scfg.len_ok && window_hit && (count_inc >= len_ext)) begin
      if (scfg.forward) begin
        qualify = !match_seen &&
                  (CMP_BITS'(start_pos) >= CMP_BITS'(scfg.start_offset));
      end else begin
        qualify = CMP_BITS'(count_inc) <= CMP_BITS'(scfg.start_offset);
      end
    end
    byte_count_next  = counting ? count_inc : byte_count;
    match_seen_next  = match_seen || qualify;
    best_offset_next = qualify ? start_pos[OFFSET_BITS-1:0] : best_offset;
    res_new.found        = match_seen_next;
    res_new.match_offset = match_seen_next ? best_offset_next : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count  <= '0;
      match_seen  <= 1'b0;
      best_offset <= '0;
    end else if (accept) begin
      if (last_byte) begin
        byte_count  <= '0;
        match_seen  <= 1'b0;
        best_offset <= '0;
      end else begin
        byte_count  <= byte_count_next;
        match_seen  <= match_seen_next;
        best_offset <= best_offset_next;
      end
    end
  end

  // Output register plus one skid entry; input stalls only when the skid is full.
  assign push       = accept && last_byte;
  assign item_stall = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (!result_valid || !result_stall) begin
      if (skid_valid) begin
        result_valid <= 1'b1;
        skid_valid   <= 1'b0;
      end else begin
        result_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!result_valid || !result_stall) begin
      if (skid_valid) result <= skid;
      else if (push) result <= res_new;
    end else if (push) begin
      skid <= res_new;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/byte_pattern_search.sv -----
// byte_pattern_search: top level; configuration registers, the row of window
// cells and the controller. Depends on bps_pkg, bps_cell and bps_ctrl.
`default_nettype none

// Streams a buffer one byte per clock while the input is not stalled and looks for
// a pattern of up to 16 bytes (optionally ASCII case-insensitive). The row of
// window cells compares all pattern positions against the arriving byte in the
// cycle it is accepted. The byte marked last yields one result, which goes into the
// output register, or into the skid entry while the output is stalled; up to two
// results can wait downstream before the input stalls. Forward mode reports the
// first match starting at or after start_offset, backward mode the last match
// ending at or before it. No clearing pass after reset. Configuration writes are
// always taken (cfg_ready is tied high) and must only be issued while idle.
module byte_pattern_search
  import bps_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      item_valid,
  output logic                           item_stall,
  input  wire item_t                     item,
  output logic                           result_valid,
  input  wire logic                      result_stall,
  output result_t                        result,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_data
);

  logic [63:0]           pattern_low_bytes;
  logic [63:0]           pattern_high_bytes;
  logic [LEN_BITS-1:0]   pattern_length;
  logic [START_BITS-1:0] start_offset;
  logic                  search_forward;
  logic                  fold_case;

  logic                  accept;
  logic [7:0]            pat_bytes [PAT_BYTES];
  logic [7:0]            window [CELL_COUNT];
  logic [CELL_COUNT-1:0] hits;
  search_cfg_t           scfg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low_bytes  <= '0;
      pattern_high_bytes <= '0;
      pattern_length     <= '0;
      start_offset       <= '0;
      search_forward     <= 1'b1;
      fold_case          <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PATTERN_LOW:  pattern_low_bytes  <= cfg_data[63:0];
        REG_PATTERN_HIGH: pattern_high_bytes <= cfg_data[63:0];
        REG_PATTERN_LEN:  pattern_length     <= cfg_data[LEN_BITS-1:0];
        REG_START_OFFSET: start_offset       <= cfg_data[START_BITS-1:0];
        REG_SEARCH_FWD:   search_forward     <= cfg_data[0];
        REG_FOLD_CASE:    fold_case          <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      pat_bytes[k]     = pattern_low_bytes[8*k +: 8];
      pat_bytes[k + 8] = pattern_high_bytes[8*k +: 8];
    end
  end

  assign accept = item_valid && !item_stall;

  // Cell j holds window byte j (newest at 0) and checks the byte entering it against
  // pattern byte length-1-j.
  for (genvar j = 0; j < CELL_COUNT; j++) begin : g_cell
    logic [7:0]          byte_in;
    logic [LEN_BITS-1:0] pidx;

    if (j == 0) begin : g_head
      assign byte_in = item.data_byte;
    end else begin : g_tail
      assign byte_in = window[j-1];
    end

    assign pidx = pattern_length - LEN_BITS'(j + 1);

    bps_cell u_cell (
      .clk      (clk),
      .shift    (accept),
      .byte_in  (byte_in),
      .pat_byte (pat_bytes[pidx[LEN_BITS-2:0]]),
      .fold_case(fold_case),
      .active   (LEN_BITS'(j) < pattern_length),
      .byte_out (window[j]),
      .hit      (hits[j])
    );
  end

  always_comb begin
    scfg.len_ok       = (pattern_length != '0) && (pattern_length <= LEN_BITS'(PAT_LIMIT));
    scfg.length       = pattern_length;
    scfg.start_offset = start_offset;
    scfg.forward      = search_forward;
  end

  bps_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .last_byte   (item.last_byte),
    .window_hit  (&hits),
    .scfg        (scfg),
    .item_stall  (item_stall),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
  );

endmodule

`default_nettype wire
